// ===== design/swm_pkg.sv =====
// Shared types and constants for the sliding window minimum block.
package swm_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int CFG_W      = 7;
  localparam int GROUP_SIZE = 8;
  localparam int GROUP_W    = 3;

  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

// ===== design/sliding_window_minimum.sv =====
// Sliding window minimum over a stream of signed samples, built as a chain of min cells.
// Path: a sample that completes a window reaches m_tvalid once the cells and the pending
// selection update at its transfer edge, then through the group select and output registers.
// Throughput: one sample per cycle; the input stalls only while all three stages are full
// and the waiting result is not taken.
// Reset: synchronous, active high; clears the window length count, fill count and all
// valid flags, and sets window_size to 3. The cell contents need no reset.
module sliding_window_minimum #(
  parameter int WINDOW_MAX = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [6:0]  cfg_wdata,  // window_size
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // [31:0] sample
  input  logic [0:0]  s_tuser,    // [0] start_new
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata     // [31:0] window_min
);
  import swm_pkg::*;

  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int CW     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int NGRP   = (WINDOW_MAX + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GSEL_W = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int SEL_W  = GROUP_W + GSEL_W;

  // Cell k holds the minimum of the last k+1 samples. The samples still alive since the
  // last start form a run of live_len most recent ones, so the answer is cell live_len-1.
  logic [CFG_W-1:0] window_size;
  logic [CNT_W-1:0] live_len;
  logic [CNT_W-1:0] fill_count;
  logic             pend_valid;
  logic [SEL_W-1:0] pend_sel;

  logic [CW-1:0]    cfg_ext;
  logic [CW-1:0]    w_eff_wide;
  logic [CNT_W-1:0] w_eff;
  logic [CNT_W-1:0] w_last;
  logic             start;
  logic [CNT_W-1:0] base_len;
  logic [CNT_W-1:0] keep_len;
  logic [CNT_W-1:0] live_len_next;
  logic [CNT_W-1:0] base_fill;
  logic [CNT_W-1:0] fill_count_next;
  logic             full;
  logic             accept;
  logic             pend_ready;
  sample_t          sample;
  sample_t          run_min [WINDOW_MAX];

  assign sample = sample_t'(s_tdata);
  assign start  = s_tuser[0];

  // Clamp the window into 1..WINDOW_MAX.
  assign cfg_ext    = CW'(window_size);
  assign w_eff_wide = (cfg_ext == '0) ? CW'(1) :
                      (cfg_ext > CW'(WINDOW_MAX)) ? CW'(WINDOW_MAX) : cfg_ext;
  assign w_eff      = w_eff_wide[CNT_W-1:0];
  assign w_last     = w_eff - CNT_W'(1);

  // Drop every aged-out sample at once, then count the new one in.
  assign base_len      = start ? '0 : live_len;
  assign keep_len      = (base_len < w_last) ? base_len : w_last;
  assign live_len_next = keep_len + CNT_W'(1);

  // Fill count saturates; a result is due once a whole window has arrived.
  assign base_fill       = start ? '0 : fill_count;
  assign full            = ({1'b0, base_fill} + (CNT_W + 1)'(1)) >= {1'b0, w_eff};
  assign fill_count_next = (base_fill < CNT_W'(WINDOW_MAX)) ? base_fill + CNT_W'(1)
                                                            : base_fill;

  // Hold the input only while a selection waits and the stage after it is blocked.
  assign s_tready = !pend_valid || pend_ready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_RESET;
      live_len    <= '0;
      fill_count  <= '0;
      pend_valid  <= 1'b0;
    end else begin
      if (cfg_wen) begin
        window_size <= cfg_wdata;
      end
      if (accept) begin
        live_len   <= live_len_next;
        fill_count <= fill_count_next;
        pend_valid <= full;
      end else if (pend_ready) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_sel <= SEL_W'(keep_len);
    end
  end

  // Advance every cell on each transfer; cell 0 simply takes the sample.
  for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
    if (k == 0) begin : g_head
      swm_cell u_cell (
        .clk      (clk),
        .en       (accept),
        .sample   (sample),
        .prev_min (sample),
        .run_min  (run_min[k])
      );
    end else begin : g_body
      swm_cell u_cell (
        .clk      (clk),
        .en       (accept),
        .sample   (sample),
        .prev_min (run_min[k-1]),
        .run_min  (run_min[k])
      );
    end
  end

  swm_select #(
    .N_CELLS (WINDOW_MAX),
    .SEL_W   (SEL_W)
  ) u_select (
    .clk        (clk),
    .rst        (rst),
    .cells      (run_min),
    .pend_valid (pend_valid),
    .pend_sel   (pend_sel),
    .pend_ready (pend_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

// ===== design/swm_cell.sv =====
// One cell of the running minimum chain: min of its left neighbour and the new sample.
module swm_cell (
  input  logic             clk,
  input  logic             en,
  input  swm_pkg::sample_t sample,
  input  swm_pkg::sample_t prev_min,
  output swm_pkg::sample_t run_min
);
  import swm_pkg::*;

  sample_t run_min_next;

  assign run_min_next = (prev_min < sample) ? prev_min : sample;

  always_ff @(posedge clk) begin
    if (en) begin
      run_min <= run_min_next;
    end
  end

endmodule

// ===== design/swm_select.sv =====
// Two-stage registered selection of one chain cell; the second stage is the output register.
module swm_select #(
  parameter int N_CELLS = 64,
  parameter int SEL_W   = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  swm_pkg::sample_t cells [N_CELLS],
  input  logic             pend_valid,
  input  logic [SEL_W-1:0] pend_sel,
  output logic             pend_ready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata
);
  import swm_pkg::*;

  localparam int NGRP   = (N_CELLS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GSEL_W = (NGRP > 1) ? $clog2(NGRP) : 1;

  sample_t             grp_cells [NGRP][GROUP_SIZE];
  sample_t             b_vals    [NGRP];
  logic [GSEL_W-1:0]   b_grp;
  logic                b_valid;
  logic                c_free;

  for (genvar i = 0; i < NGRP * GROUP_SIZE; i++) begin : g_pad
    if (i < N_CELLS) begin : g_real
      assign grp_cells[i / GROUP_SIZE][i % GROUP_SIZE] = cells[i];
    end else begin : g_zero
      assign grp_cells[i / GROUP_SIZE][i % GROUP_SIZE] = '0;
    end
  end

  assign c_free     = !m_tvalid || m_tready;
  assign pend_ready = !b_valid || c_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (pend_ready) begin
        b_valid <= pend_valid;
      end
      if (c_free) begin
        m_tvalid <= b_valid;
      end
    end
  end

  // pick within each group first, then the group
  always_ff @(posedge clk) begin
    if (pend_ready && pend_valid) begin
      for (int g = 0; g < NGRP; g++) begin
        b_vals[g] <= grp_cells[g][pend_sel[GROUP_W-1:0]];
      end
      b_grp <= pend_sel[SEL_W-1:GROUP_W];
    end
    if (c_free && b_valid) begin
      m_tdata <= b_vals[b_grp];
    end
  end

endmodule

// ===== design/swm_checker.sv =====
// Port-level checks for the sliding window minimum block, bound to the top level.
module swm_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_wen,
  input logic [6:0]  cfg_wdata,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic [0:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or vanished");

  // Reset empties the output stage.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result present after reset");

  // The input is held back only by a blocked result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output back-pressure");

endmodule

bind sliding_window_minimum swm_checker u_swm_checker (.*);

// ===== test/sliding_window_minimum_tb.sv =====
// Testbench for the sliding window minimum block: stream stimulus, window-min scoreboard.
`timescale 1ns / 1ps

module sliding_window_minimum_tb;
  import swm_pkg::*;

  localparam int WIN_MAX      = 64;
  localparam int RANDOM_ITEMS = 1450;
  localparam int DRAIN_CYCLES = 8;    // output pipeline is three stages deep, keep some margin
  localparam int MAX_REPORTS  = 200;

  // Shape of the sample values inside one random phase.
  typedef enum int {
    SHAPE_ANY,
    SHAPE_NARROW,
    SHAPE_RISING,
    SHAPE_FALLING,
    SHAPE_MIXED
  } shape_e;

  // Receiver behaviour; each mode holds for a random stretch of cycles.
  typedef enum int {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_PATTERN,
    RDY_STARVED
  } rdy_mode_e;

  // Window minimum scoreboard: keeps its own monotonic candidate queue and
  // holds the minima still to come out of the block.
  class window_min_scoreboard;
    logic [CFG_W-1:0] window_reg;
    sample_t          cand_values[$];
    logic [6:0]       cand_positions[$];
    logic [6:0]       position;
    int unsigned      fill;
    sample_t          pending_minima[$];
    int unsigned      errors;
    int unsigned      samples_taken;
    int unsigned      minima_checked;

    function new();
      window_reg     = WINDOW_RESET;
      position       = '0;
      fill           = 0;
      errors         = 0;
      samples_taken  = 0;
      minima_checked = 0;
    endfunction

    function void set_window(logic [CFG_W-1:0] value);
      window_reg = value;
    endfunction

    function int unsigned pending();
      return pending_minima.size();
    endfunction

    // Note one accepted sample and work out whether it completes a window.
    function void take_sample(sample_t value, bit start_new);
      int unsigned w;
      logic [6:0]  age;
      w = window_reg;
      if (w < 1) w = 1;
      if (w > WIN_MAX) w = WIN_MAX;
      samples_taken++;
      if (start_new) begin
        cand_values.delete();
        cand_positions.delete();
        fill = 0;
      end
      // Drop every head entry that has left the window; the 7-bit
      // subtraction gives the age modulo twice the largest window.
      while (cand_values.size() > 0) begin
        age = position - cand_positions[0];
        if (age < w) break;
        cand_values.delete(0);
        cand_positions.delete(0);
      end
      // Prune larger entries from the tail, then append this sample.
      while (cand_values.size() > 0 && cand_values[$] > value) begin
        cand_values.delete(cand_values.size() - 1);
        cand_positions.delete(cand_positions.size() - 1);
      end
      cand_values.insert(cand_values.size(), value);
      cand_positions.insert(cand_positions.size(), position);
      position = position + 1'b1;
      if (fill + 1 >= w) pending_minima.insert(pending_minima.size(), cand_values[0]);
      if (fill < WIN_MAX) fill++;
    endfunction

    // Compare one accepted result with the oldest minimum expected.
    function void check_min(sample_t got);
      sample_t want;
      if (pending_minima.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual window_min %0d",
                   $time, got);
        return;
      end
      want = pending_minima[0];
      pending_minima.delete(0);
      minima_checked++;
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: window_min mismatch, expected %0d, actual %0d", $time, want, got);
      end
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_wen   = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [SAMPLE_W-1:0] s_tdata   = '0;  // [31:0] sample
  logic [0:0]          s_tuser   = '0;  // [0] start_new
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [SAMPLE_W-1:0] m_tdata;         // [31:0] window_min

  window_min_scoreboard sb;

  int unsigned burst_left  = 0;
  int unsigned cfg_writes  = 0;
  sample_t     ramp_val    = '0;
  rdy_mode_e   rdy_mode    = RDY_ALWAYS;
  int unsigned rdy_left    = 0;
  logic [7:0]  rdy_tick    = '0;

  sliding_window_minimum #(
    .WINDOW_MAX(WIN_MAX)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Monitor both buses at the edge. Values read here are the ones from before
  // the edge, since all drivers use nonblocking assignments. Check the output
  // first: a sample transferred at this edge cannot have its result out yet.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid === 1'b1 && m_tready) sb.check_min(sample_t'(m_tdata));
      if (s_tvalid && s_tready === 1'b1) sb.take_sample(sample_t'(s_tdata), s_tuser[0]);
    end
  end

  // Receiver: switch between randomly chosen stall modes, so back-pressure lands
  // on every phase of the pipeline, with clean stretches too.
  always @(posedge clk) begin
    rdy_tick <= rdy_tick + 1'b1;
    if (rdy_left == 0) begin
      rdy_mode <= rdy_mode_e'($urandom_range(0, 3));
      rdy_left <= $urandom_range(30, 200);
    end else begin
      rdy_left <= rdy_left - 1;
    end
    case (rdy_mode)
      RDY_ALWAYS:  m_tready <= 1'b1;
      RDY_COIN:    m_tready <= ($urandom_range(0, 1) == 1);
      RDY_PATTERN: m_tready <= (rdy_tick[2:0] != 3'd0) && !(rdy_tick[4:3] == 2'd3);
      default:     m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Offer one sample and hold it until it is transferred. Between bursts,
  // drop tvalid for a random gap (sometimes none at all).
  task automatic send_sample(input sample_t value, input bit start_new);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_tvalid   <= 1'b1;
    s_tdata    <= value;
    s_tuser[0] <= start_new;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop sending and wait until every expected minimum is out and the
  // pipeline has had time to flush samples that produce no result.
  task automatic wait_idle();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the window length; only called with the block idle.
  task automatic write_window(input logic [CFG_W-1:0] value);
    wait_idle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    sb.set_window(value);
    cfg_writes++;
  endtask

  function automatic sample_t extreme_sample();
    case ($urandom_range(0, 3))
      0:       return sample_t'(32'h8000_0000);
      1:       return sample_t'(32'h7FFF_FFFF);
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic sample_t next_sample(input shape_e shape);
    if ($urandom_range(0, 15) == 0) return extreme_sample();
    case (shape)
      SHAPE_NARROW:  return sample_t'(int'($urandom_range(0, 15)) - 8);
      SHAPE_RISING: begin
        ramp_val = ramp_val + sample_t'($urandom_range(0, 3));
        return ramp_val;
      end
      SHAPE_FALLING: begin
        ramp_val = ramp_val - sample_t'($urandom_range(0, 3));
        return ramp_val;
      end
      SHAPE_MIXED:
        return ($urandom_range(0, 1) == 0) ? sample_t'($urandom)
                                           : sample_t'(int'($urandom_range(0, 63)) - 32);
      default:       return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_window();
    case ($urandom_range(0, 11))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd2;
      3:       return 7'd3;
      4:       return 7'd4;
      5:       return 7'd8;
      6:       return 7'd63;
      7:       return 7'd64;
      8:       return 7'd65;
      9:       return 7'd127;
      default: return CFG_W'($urandom_range(1, 20));
    endcase
  endfunction

  initial begin
    int unsigned      target;
    int unsigned      phase_len;
    int unsigned      eff;
    logic [CFG_W-1:0] win;
    shape_e           shape;

    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset window of three, with the field extremes and ties.
    send_sample(sample_t'(32'h7FFF_FFFF), 1'b1);
    send_sample(sample_t'(32'h8000_0000), 1'b0);
    send_sample('0, 1'b0);
    send_sample('1, 1'b0);
    send_sample(sample_t'(5), 1'b0);
    send_sample(sample_t'(5), 1'b0);
    send_sample(sample_t'(3), 1'b0);
    send_sample(sample_t'(10), 1'b0);
    send_sample(sample_t'(20), 1'b0);
    send_sample(sample_t'(30), 1'b0);
    send_sample(sample_t'(7), 1'b1);
    send_sample(sample_t'(7), 1'b0);

    // Window of zero behaves as a window of one.
    write_window(7'd0);
    send_sample('1, 1'b0);
    send_sample(sample_t'(32'h7FFF_FFFF), 1'b0);
    send_sample(sample_t'(32'h8000_0000), 1'b0);

    // Oversized window saturates at the maximum; fill an ascending run.
    write_window(7'd127);
    send_sample(sample_t'(1), 1'b1);
    send_sample(sample_t'(2), 1'b0);
    send_sample(sample_t'(3), 1'b0);
    send_sample(sample_t'(4), 1'b0);

    // Shrink mid-stream: several aged heads must go in one step.
    write_window(7'd2);
    send_sample(sample_t'(9), 1'b0);
    send_sample(sample_t'(8), 1'b0);

    // Grow mid-stream: dropped samples stay dropped.
    write_window(7'd64);
    send_sample(sample_t'(6), 1'b0);
    send_sample(sample_t'(-6), 1'b0);

    // Random phases: a window setting, a value shape, and a run of samples
    // with occasional restarts. No start at the phase edge exercises
    // mid-stream shrink and grow again.
    target = sb.samples_taken + RANDOM_ITEMS;
    while (sb.samples_taken < target) begin
      win = pick_window();
      write_window(win);
      eff = (win == 0) ? 1 : ((win > WIN_MAX) ? WIN_MAX : win);
      shape = shape_e'($urandom_range(0, 4));
      ramp_val = sample_t'($urandom);
      phase_len = (eff > 16) ? eff + $urandom_range(10, 80) : $urandom_range(20, 120);
      for (int unsigned i = 0; i < phase_len; i++)
        send_sample(next_sample(shape),
                    (i == 0) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 99) == 0));
    end

    wait_idle();
    $display("Summary: %0d samples transferred, %0d window minima checked",
             sb.samples_taken, sb.minima_checked);
    $display("Summary: %0d window length writes, including zero and oversized values",
             cfg_writes);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
